// File: rtl/lkw_pkg.sv
`default_nettype none

package lkw_pkg;

  localparam int NUM_CPUS_DEF = 8;
  localparam int MAX_SLOTS    = 8;
  localparam int DW           = 64;
  localparam int CNT_W        = 32;
  localparam int STAMP_W      = 34;
  localparam int STAMP_LSB    = 30;
  localparam int STALL_W      = 63;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [7:0]  MASK_RST     = 8'hFF;
  localparam logic [7:0]  THR_RST      = 8'd20;
  localparam logic        KICK_SUP_RST = 1'b0;
  localparam logic [31:0] LIMIT_RST    = 32'd5000000;

  typedef enum logic [1:0] {
    REG_CPU_MASK,
    REG_THRESHOLD,
    REG_KICK_SUP,
    REG_PANIC_LIMIT
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_RUN,
    OP_KICK,
    OP_TOUCH_ALL
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STALL,
    ST_LOCK,
    ST_THR,
    ST_SCAN,
    ST_DELAY,
    ST_PANIC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  cpu_mask;
    logic [7:0]  threshold;
    logic        kick_sup;
    logic [31:0] panic_limit;
  } cfg_t;

  typedef struct packed {
    logic [DW-1:0] diff;
    logic          ge;
  } alu_res_t;

endpackage

`default_nettype wire

// File: rtl/multi_cpu_lockup_watchdog_top.sv
// Non-tick items and unsupervised ticks pass from EXEC straight to DONE; ticks
// without alert pass through STALL, LOCK and THR (or STALL alone for an untouched
// CPU); alert ticks add the kick stamp scan over every slot, then DELAY and PANIC,
// all through the shared subtractor. One item at a time: a new input transfer is
// accepted only once the result has been loaded and the sequencer is back in idle.
// Synchronous reset clears config to defaults and all per-CPU state to zero.
`default_nettype none

module multi_cpu_lockup_watchdog_top import lkw_pkg::*; #(
  parameter int NUM_CPUS = NUM_CPUS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         op,
  input  logic [2:0]         cpu,
  input  logic [DW-1:0]      clock_ns,
  input  logic [DW-1:0]      cpu_time_us,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               alert,
  output logic               first_warning,
  output logic               panic,
  output logic [STAMP_W-1:0] lockup_seconds,
  output logic [STALL_W-1:0] kick_stall_us,
  output logic [3:0]         last_kick_cpu,
  output logic [DW-1:0]      last_kick_delay_ns
);

  cfg_t cfg;

  lkw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lkw_seq #(
    .NUM_CPUS (NUM_CPUS)
  ) u_seq (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .op                 (op),
    .cpu                (cpu),
    .clock_ns           (clock_ns),
    .cpu_time_us        (cpu_time_us),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .alert              (alert),
    .first_warning      (first_warning),
    .panic              (panic),
    .lockup_seconds     (lockup_seconds),
    .kick_stall_us      (kick_stall_us),
    .last_kick_cpu      (last_kick_cpu),
    .last_kick_delay_ns (last_kick_delay_ns)
  );

endmodule

`default_nettype wire

// File: rtl/lkw_alu.sv
`default_nettype none

module lkw_alu import lkw_pkg::*; (
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  output alu_res_t      res
);

  logic [DW:0] full;

  // a - b; carry out set when a >= b
  assign full     = {1'b0, a} + {1'b0, ~b} + {{DW{1'b0}}, 1'b1};
  assign res.diff = full[DW-1:0];
  assign res.ge   = full[DW];

endmodule

`default_nettype wire

// File: rtl/lkw_cfg.sv
`default_nettype none

module lkw_cfg import lkw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t ridx;
  logic     wr;

  assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpu_mask    <= MASK_RST;
      cfg.threshold   <= THR_RST;
      cfg.kick_sup    <= KICK_SUP_RST;
      cfg.panic_limit <= LIMIT_RST;
    end else if (wr) begin
      case (ridx)
        REG_CPU_MASK:    cfg.cpu_mask    <= pwdata[7:0];
        REG_THRESHOLD:   cfg.threshold   <= pwdata[7:0];
        REG_KICK_SUP:    cfg.kick_sup    <= pwdata[0];
        REG_PANIC_LIMIT: cfg.panic_limit <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CPU_MASK:    prdata = {24'b0, cfg.cpu_mask};
      REG_THRESHOLD:   prdata = {24'b0, cfg.threshold};
      REG_KICK_SUP:    prdata = {31'b0, cfg.kick_sup};
      REG_PANIC_LIMIT: prdata = cfg.panic_limit;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lkw_seq.sv
`default_nettype none

module lkw_seq import lkw_pkg::*; #(
  parameter int NUM_CPUS = NUM_CPUS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         op,
  input  logic [2:0]         cpu,
  input  logic [DW-1:0]      clock_ns,
  input  logic [DW-1:0]      cpu_time_us,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               alert,
  output logic               first_warning,
  output logic               panic,
  output logic [STAMP_W-1:0] lockup_seconds,
  output logic [STALL_W-1:0] kick_stall_us,
  output logic [3:0]         last_kick_cpu,
  output logic [DW-1:0]      last_kick_delay_ns
);

  localparam int NSLOT = (NUM_CPUS < MAX_SLOTS) ? NUM_CPUS : MAX_SLOTS;
  localparam int IW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam logic [3:0] NO_KICK = 4'(NUM_CPUS);

  state_t state, state_next;

  op_t               op_r;
  logic [2:0]        cpu_r;
  logic [DW-1:0]     clk_r;
  logic [DW-1:0]     now_us_r;
  logic [STAMP_W-1:0] now_stamp;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     idx;

  logic [STAMP_W-1:0] touch_stamp     [NSLOT];
  logic [CNT_W-1:0]   kick_count      [NSLOT];
  logic [CNT_W-1:0]   kick_count_seen [NSLOT];
  logic [DW-1:0]      stall_start_us  [NSLOT];
  logic [DW-1:0]      kick_stamp_ns   [NSLOT];
  logic [NSLOT-1:0]   warned;

  logic               stalled;
  logic               backwards;
  logic               lock_ok;
  logic [STAMP_W-1:0] lock_diff;
  logic [DW-1:0]      best;

  logic               r_alert;
  logic               r_first;
  logic               r_panic;
  logic [STAMP_W-1:0] r_lock;
  logic [STALL_W-1:0] r_stall;
  logic [3:0]         r_who;
  logic [DW-1:0]      r_delay;

  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_b;
  alu_res_t      alu_res;

  logic cpu_ok;
  logic sup_c;
  logic same_count;
  logic stall_now;
  logic over;
  logic alert_now;
  logic out_free;
  logic scan_last;

  lkw_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign now_stamp  = clk_r[DW-1:STAMP_LSB];
  assign slot       = cpu_r[IW-1:0];
  assign cpu_ok     = int'(cpu_r) < NUM_CPUS;
  assign sup_c      = cpu_ok & cfg.cpu_mask[cpu_r];
  assign same_count = kick_count_seen[slot] == kick_count[slot];
  assign stall_now  = cfg.kick_sup & same_count & (stall_start_us[slot] != '0) &
                      (alu_res.diff != '0);
  assign over       = lock_ok & ~alu_res.ge;
  assign alert_now  = over | stalled;
  assign out_free   = ~result_valid | result_ready;
  assign scan_last  = int'(idx) == NSLOT - 1;
  assign item_ready = state == ST_IDLE;

  always_comb begin
    case (state)
      ST_STALL: begin
        alu_a = now_us_r;
        alu_b = stall_start_us[slot];
      end
      ST_LOCK: begin
        alu_a = {30'b0, now_stamp};
        alu_b = {30'b0, touch_stamp[slot]};
      end
      ST_THR: begin
        alu_a = {56'b0, cfg.threshold};
        alu_b = {30'b0, lock_diff};
      end
      ST_SCAN: begin
        alu_a = best;
        alu_b = kick_stamp_ns[idx];
      end
      ST_DELAY: begin
        alu_a = clk_r;
        alu_b = best;
      end
      ST_PANIC: begin
        alu_a = {1'b0, r_stall};
        alu_b = {32'b0, cfg.panic_limit};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (item_valid) state_next = ST_EXEC;
      ST_EXEC:  state_next = (op_r == OP_TICK && sup_c) ? ST_STALL : ST_DONE;
      ST_STALL: state_next = (touch_stamp[slot] == '0 && !stall_now) ? ST_DONE : ST_LOCK;
      ST_LOCK:  state_next = ST_THR;
      ST_THR:   state_next = alert_now ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_last) state_next = ST_DELAY;
      ST_DELAY: state_next = ST_PANIC;
      ST_PANIC: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      alert              <= r_alert;
      first_warning      <= r_first;
      panic              <= r_panic;
      lockup_seconds     <= r_lock;
      kick_stall_us      <= r_stall;
      last_kick_cpu      <= r_who;
      last_kick_delay_ns <= r_delay;
    end
  end

  // per-CPU state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) begin
        touch_stamp[i]     <= '0;
        kick_count[i]      <= '0;
        kick_count_seen[i] <= '0;
        stall_start_us[i]  <= '0;
        kick_stamp_ns[i]   <= '0;
      end
      warned <= '0;
    end else begin
      case (state)
        ST_EXEC: begin
          case (op_r)
            OP_RUN: begin
              if (cpu_ok) touch_stamp[slot] <= now_stamp;
            end
            OP_KICK: begin
              if (cpu_ok) begin
                for (int i = 0; i < NSLOT; i++) begin
                  if (cfg.cpu_mask[i]) kick_count[i] <= kick_count[i] + 32'd1;
                end
                touch_stamp[slot]   <= now_stamp;
                kick_stamp_ns[slot] <= clk_r;
              end
            end
            OP_TOUCH_ALL: begin
              for (int i = 0; i < NSLOT; i++) begin
                if (cfg.cpu_mask[i]) touch_stamp[i] <= '0;
              end
            end
            default: ;
          endcase
        end
        ST_STALL: begin
          if (cfg.kick_sup) begin
            if (same_count) begin
              if (stall_start_us[slot] == '0) stall_start_us[slot] <= now_us_r;
            end else begin
              stall_start_us[slot]  <= '0;
              kick_count_seen[slot] <= kick_count[slot];
            end
          end
          if (touch_stamp[slot] == '0 && !stall_now) touch_stamp[slot] <= now_stamp;
        end
        ST_THR: warned[slot] <= alert_now;
        default: ;
      endcase
    end
  end

  // item registers and working result
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          op_r     <= op_t'(op);
          cpu_r    <= cpu;
          clk_r    <= clock_ns;
          now_us_r <= cpu_time_us;
        end
      end
      ST_EXEC: begin
        r_alert   <= 1'b0;
        r_first   <= 1'b0;
        r_panic   <= 1'b0;
        r_lock    <= '0;
        r_stall   <= '0;
        r_who     <= NO_KICK;
        r_delay   <= '0;
        stalled   <= 1'b0;
        backwards <= 1'b0;
        best      <= '0;
        idx       <= '0;
      end
      ST_STALL: begin
        stalled   <= stall_now;
        backwards <= stall_now & alu_res.diff[DW-1];
        r_stall   <= (stall_now && !alu_res.diff[DW-1]) ? alu_res.diff[STALL_W-1:0] : '0;
      end
      ST_LOCK: begin
        lock_ok   <= alu_res.ge;
        lock_diff <= alu_res.diff[STAMP_W-1:0];
      end
      ST_THR: begin
        if (alert_now) begin
          r_alert <= 1'b1;
          r_first <= ~warned[slot];
          r_lock  <= over ? lock_diff : '0;
        end
      end
      ST_SCAN: begin
        if (!alu_res.ge) begin
          best  <= kick_stamp_ns[idx];
          r_who <= 4'(idx);
        end
        idx <= idx + 1'b1;
      end
      ST_DELAY: r_delay <= alu_res.diff;
      ST_PANIC: r_panic <= stalled & ~backwards & alu_res.ge;
      default: ;
    endcase
  end

endmodule

`default_nettype wire
